// ===== rtl/core/wrcm_pkg.sv =====
// shared types, constants and the gradient color table for the waterfall row colormapper
// no dependencies
`timescale 1ns / 1ps

package wrcm_pkg;

	localparam int ROW_WIDTH_DEFAULT = 240;
	localparam int MAX_BINS_DEFAULT = 1024;
	localparam int PIXELS_PER_RESULT = 4;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_AUTOSCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_ROWS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_ROWS = 2'd2;

	typedef struct packed {
		logic we;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// scale registers are unsigned fixed point with 16 fraction bits
	localparam logic [23:0] SCALE_LOW_RST = 24'h280000;
	localparam logic [24:0] SCALE_HIGH_RST = 25'h0C80000;
	localparam logic [24:0] SCALE_HIGH_FULL = 25'h0FF0000;
	localparam logic [24:0] FX_ONE = 25'h0010000;

	localparam logic [8:0] HEADER_ROWS_RST = 9'd50;
	localparam logic [8:0] SCROLL_ROWS_RST = 9'd270;
	localparam logic [8:0] SCROLL_POS_RST = 9'd50;

	localparam int MIN_VALID = 10;
	localparam logic [8:0] HI_MARGIN = 9'd12;
	localparam logic [8:0] SPAN_MIN = 9'd20;
	// divide by ten for a 30 bit dividend: ceil(2^34 / 10), product taken from bit 34 up
	localparam logic [30:0] EMA_RECIP = 31'd1717986919;
	localparam logic [29:0] EMA_ROUND = 30'd5;
	// 9/10 as a 16 bit reciprocal: 9 * ceil(65536 / 10)
	localparam logic [31:0] CEL_RECIP = 32'd58986;

	localparam logic [15:0] GREY565 = 16'h2945;

	typedef logic [15:0] ctab_t [256];

	function automatic logic [15:0] grad565(int unsigned i);
		int unsigned r;
		int unsigned g;
		int unsigned b;
		r = 0;
		g = 0;
		b = 0;
		if (i <= 38) begin
			b = 440 * i / 153;
		end else if (i <= 89) begin
			g = 60 * (4 * i - 153) / 204;
			b = 110 + 145 * (4 * i - 153) / 204;
		end else if (i <= 140) begin
			g = 60 + 195 * (4 * i - 357) / 204;
			b = 255;
		end else if (i <= 178) begin
			g = 255;
			b = 255 * (714 - 4 * i) / 153;
		end else if (i <= 209) begin
			r = 255 * (10 * i - 1785) / 306;
			g = 255;
		end else if (i <= 237) begin
			r = 255;
			g = 255 * (23715 - 100 * i) / 2805;
		end else begin
			r = 255;
			g = 255 * (100 * i - 23715) / 1785;
			b = g;
		end
		return 16'(((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3));
	endfunction

	function automatic ctab_t build_ctab();
		ctab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = grad565(i);
		end
		return t;
	endfunction

	localparam ctab_t COLOUR_TABLE = build_ctab();

endpackage

// ===== rtl/core/waterfall_row_colormapper_core.sv =====
// top level of the waterfall row colormapper: input side, bin store and row engine
// depends on wrcm_pkg, wrcm_front, wrcm_bin_mem, wrcm_back
// after the last bin of a line: row work, then pixel mapping in a restoring divider
// throughput: one bin per cycle while fewer than two lines are queued or in work;
//   rows are produced one at a time, each result one transaction of four pixels
// reset: asynchronous, clears control, sets scale to 40.0/200.0 and scroll row 50; no sweep
`timescale 1ns / 1ps

module waterfall_row_colormapper_core #(
	parameter int ROW_WIDTH = wrcm_pkg::ROW_WIDTH_DEFAULT,
	parameter int MAX_BINS = wrcm_pkg::MAX_BINS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] bin_value,
	input  logic last_bin,
	output logic out_valid,
	input  logic out_ready,
	output logic [15:0] pixel_a,
	output logic [15:0] pixel_b,
	output logic [15:0] pixel_c,
	output logic [15:0] pixel_d,
	output logic [7:0] pixel_column,
	output logic [8:0] row_address,
	output logic last_of_row,
	input  logic cfg_write_en,
	input  logic [wrcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wrcm_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int NW = $clog2(MAX_BINS + 1);
	localparam int MA = $clog2(MAX_BINS) + 1;

	wrcm_pkg::cfg_wr_t cfg;
	logic back_busy;
	logic pop;
	logic q_valid;
	logic q_bank;
	logic [NW-1:0] q_n;
	logic mem_we;
	logic [MA-1:0] mem_waddr;
	logic [7:0] mem_wdata;
	logic [MA-1:0] mem_raddr;
	logic [7:0] mem_rdata;

	assign cfg.we = cfg_write_en;
	assign cfg.idx = cfg_index;
	assign cfg.data = cfg_data;

	wrcm_front #(
		.MAX_BINS(MAX_BINS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.bin_value(bin_value),
		.last_bin(last_bin),
		.back_busy(back_busy),
		.pop(pop),
		.q_valid(q_valid),
		.q_bank(q_bank),
		.q_n(q_n),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata)
	);

	wrcm_bin_mem #(
		.MAX_BINS(MAX_BINS)
	) u_bin_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	wrcm_back #(
		.ROW_WIDTH(ROW_WIDTH),
		.MAX_BINS(MAX_BINS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.q_valid(q_valid),
		.q_bank(q_bank),
		.q_n(q_n),
		.pop(pop),
		.busy(back_busy),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_a(pixel_a),
		.pixel_b(pixel_b),
		.pixel_c(pixel_c),
		.pixel_d(pixel_d),
		.pixel_column(pixel_column),
		.row_address(row_address),
		.last_of_row(last_of_row)
	);

endmodule

// ===== rtl/core/wrcm_bin_mem.sv =====
// double-banked spectrum bin store, one write and one registered read port
// no package dependencies
`timescale 1ns / 1ps

module wrcm_bin_mem #(
	parameter int MAX_BINS = 1024
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(MAX_BINS):0] waddr,
	input  logic [7:0] wdata,
	input  logic [$clog2(MAX_BINS):0] raddr,
	output logic [7:0] rdata
);

	localparam int DEPTH = 2 * MAX_BINS;

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/wrcm_front.sv =====
// input side: bin counting per line, bank selection and a two-entry line queue
// depends on wrcm_pkg only through the instantiating top level
`timescale 1ns / 1ps

module wrcm_front #(
	parameter int MAX_BINS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] bin_value,
	input  logic last_bin,
	input  logic back_busy,
	input  logic pop,
	output logic q_valid,
	output logic q_bank,
	output logic [$clog2(MAX_BINS+1)-1:0] q_n,
	output logic mem_we,
	output logic [$clog2(MAX_BINS):0] mem_waddr,
	output logic [7:0] mem_wdata
);

	localparam int AW = $clog2(MAX_BINS);
	localparam int NW = $clog2(MAX_BINS + 1);

	logic [NW-1:0] cnt_q;
	logic fbank_q;
	logic ent_bank_q [2];
	logic [NW-1:0] ent_n_q [2];
	logic wptr_q;
	logic rptr_q;
	logic [1:0] qcnt_q;

	logic accept;
	logic push;
	logic room;
	logic [NW-1:0] n_push;

	// a bank is free while fewer than two lines are queued or in work
	assign in_ready = ({1'b0, qcnt_q} + {2'b00, back_busy}) < 3'd2;
	assign accept = in_valid && in_ready;
	assign push = accept && last_bin;
	assign room = cnt_q < NW'(MAX_BINS);
	assign n_push = room ? cnt_q + NW'(1) : cnt_q;

	assign mem_we = accept && room;
	assign mem_waddr = {fbank_q, cnt_q[AW-1:0]};
	assign mem_wdata = bin_value;

	assign q_valid = qcnt_q != 2'd0;
	assign q_bank = ent_bank_q[rptr_q];
	assign q_n = ent_n_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			fbank_q <= 1'b0;
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			qcnt_q <= 2'd0;
			ent_bank_q[0] <= 1'b0;
			ent_bank_q[1] <= 1'b0;
			ent_n_q[0] <= '0;
			ent_n_q[1] <= '0;
		end else begin
			if (accept) begin
				if (push) begin
					cnt_q <= '0;
				end else if (room) begin
					cnt_q <= cnt_q + NW'(1);
				end
			end
			if (push) begin
				ent_bank_q[wptr_q] <= fbank_q;
				ent_n_q[wptr_q] <= n_push;
				wptr_q <= ~wptr_q;
				fbank_q <= ~fbank_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				qcnt_q <= qcnt_q + 2'd1;
			end else if (pop && !push) begin
				qcnt_q <= qcnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/core/wrcm_back.sv =====
// row engine: decimation, histogram, percentile, scale tracking, color mapping, output register
// depends on wrcm_pkg (config struct, constants, color table)
`timescale 1ns / 1ps

module wrcm_back #(
	parameter int ROW_WIDTH = 240,
	parameter int MAX_BINS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  wrcm_pkg::cfg_wr_t cfg,
	input  logic q_valid,
	input  logic q_bank,
	input  logic [$clog2(MAX_BINS+1)-1:0] q_n,
	output logic pop,
	output logic busy,
	output logic [$clog2(MAX_BINS):0] mem_raddr,
	input  logic [7:0] mem_rdata,
	output logic out_valid,
	input  logic out_ready,
	output logic [15:0] pixel_a,
	output logic [15:0] pixel_b,
	output logic [15:0] pixel_c,
	output logic [15:0] pixel_d,
	output logic [7:0] pixel_column,
	output logic [8:0] row_address,
	output logic last_of_row
);

	localparam int PPR = wrcm_pkg::PIXELS_PER_RESULT;
	localparam int AW = $clog2(MAX_BINS);
	localparam int NW = $clog2(MAX_BINS + 1);
	localparam int XW = $clog2(ROW_WIDTH);
	localparam int RW = $clog2(ROW_WIDTH) + 1;
	localparam int HW = $clog2(ROW_WIDTH + 1);
	localparam int CW = $clog2(ROW_WIDTH + PPR);
	localparam int JW = $clog2(PPR);
	localparam logic [RW-1:0] W_R = RW'(ROW_WIDTH);
	localparam logic [JW-1:0] J_LAST = JW'(PPR - 1);
	// bin count over row width by reciprocal multiplication, exact for every count
	localparam int DSH = NW + RW;
	localparam int PW = NW + DSH;
	localparam int MW = NW + RW;
	localparam logic [63:0] DRECIP = ((64'd1 << DSH) + 64'(ROW_WIDTH) - 64'd1) / 64'(ROW_WIDTH);

	typedef enum logic [4:0] {
		S_IDLE, S_DIVN, S_DREM, S_PSET, S_RD, S_ACC, S_HRD, S_HWR, S_PNEXT, S_SCHK,
		S_PRD, S_PACC, S_EINIT, S_EDIV, S_MSTART, S_MRD, S_MCALC, S_MDIV,
		S_MLUT, S_EMIT
	} state_t;

	state_t state_q;

	logic autoscale_q;
	logic [8:0] header_q;
	logic [8:0] scroll_q;
	logic [23:0] lo_q;
	logic [24:0] hi_q;
	logic [8:0] pos_q;
	logic busy_q;
	logic bank_q;

	logic [NW-1:0] dv_q;
	logic [NW-1:0] qs_q;
	logic [RW-1:0] rs_q;
	logic [NW-1:0] a_q;
	logic [RW-1:0] ar_q;
	logic [NW-1:0] nb_q;
	logic [RW-1:0] nbr_q;
	logic [NW-1:0] end_q;
	logic [NW-1:0] i_q;
	logic [7:0] m_q;
	logic [XW-1:0] x_q;

	logic [255:0] hvalid_q;
	logic [HW-1:0] nvalid_q;
	logic [7:0] mn_q;
	logic [HW-1:0] cel_q;
	logic [HW-1:0] acc_q;
	logic [7:0] hidx_q;
	logic [8:0] lo_t_q;
	logic [8:0] hi_t_q;
	logic esel_q;
	logic [29:0] ediv_q;

	logic [24:0] span_q;
	logic [31:0] num_q;
	logic [32:0] dsh_q;
	logic [7:0] q8_q;
	logic [3:0] scnt_q;
	logic [CW-1:0] col_q;
	logic [JW-1:0] j_q;
	logic [15:0] grp_q [PPR];

	logic out_valid_q;
	logic [15:0] pix_out_q [PPR];
	logic [7:0] col_out_q;
	logic [8:0] row_out_q;
	logic last_out_q;

	logic [HW-1:0] hist_mem [256];
	logic [HW-1:0] hist_rd_q;
	logic [7:0] row_mem [ROW_WIDTH];
	logic [7:0] row_rd_q;

	// scroll row
	logic [8:0] rows_c;
	logic [8:0] last_row_c;
	logic [8:0] new_pos_c;
	// bin count over row width
	logic [PW-1:0] dprod_c;
	logic [MW-1:0] dmul_c;
	logic [NW-1:0] drem_c;
	// pixel span
	logic [RW-1:0] sum_r_c;
	logic carry_c;
	logic [NW-1:0] nb_c;
	logic [RW-1:0] nbr_c;
	logic [NW-1:0] end_c;
	logic [7:0] mnew_c;
	logic span_done_c;
	logic row_we_c;
	// histogram and percentile
	logic hist_we_c;
	logic [7:0] hist_addr_c;
	logic [HW-1:0] hist_wdata_c;
	logic [HW-1:0] accn_c;
	logic [31:0] cel_prod_c;
	logic [8:0] p12_c;
	logic [8:0] mn20_c;
	logic [8:0] hit_c;
	// moving average, divide by ten through the reciprocal
	logic [24:0] old_c;
	logic [8:0] tgt_c;
	logic [29:0] ema_in_c;
	logic [60:0] eprod_c;
	logic [24:0] eres_c;
	// mapping
	logic [25:0] lo_one_c;
	logic [24:0] span_c;
	logic [23:0] vfx_c;
	logic [23:0] diff_c;
	logic [31:0] num_c;
	logic mge_c;
	logic [CW-1:0] colj_c;
	logic in_range_c;
	logic row_rd_en_c;
	logic last_res_c;
	logic out_load_c;

	always_comb begin
		rows_c = (scroll_q == 9'd0) ? 9'd1 : scroll_q;
		last_row_c = header_q + rows_c - 9'd1;
		new_pos_c = (pos_q <= header_q || pos_q > last_row_c) ? last_row_c : pos_q - 9'd1;

		dprod_c = PW'(dv_q) * PW'(DRECIP);
		dmul_c = MW'(qs_q) * MW'(ROW_WIDTH);
		drem_c = dv_q - dmul_c[NW-1:0];

		sum_r_c = ar_q + rs_q;
		carry_c = sum_r_c >= W_R;
		nb_c = a_q + qs_q + NW'(carry_c);
		nbr_c = carry_c ? sum_r_c - W_R : sum_r_c;
		end_c = (nb_c > a_q) ? nb_c : a_q + NW'(1);
		mnew_c = (mem_rdata > m_q) ? mem_rdata : m_q;
		span_done_c = (i_q + NW'(1)) == end_q;
		row_we_c = (state_q == S_ACC) && span_done_c;

		hist_we_c = state_q == S_HWR;
		hist_addr_c = (state_q == S_PRD) ? hidx_q : m_q;
		hist_wdata_c = (hvalid_q[m_q] ? hist_rd_q : '0) + HW'(1);
		accn_c = acc_q + (hvalid_q[hidx_q] ? hist_rd_q : '0);
		cel_prod_c = 32'(nvalid_q) * wrcm_pkg::CEL_RECIP;
		p12_c = {1'b0, hidx_q} + wrcm_pkg::HI_MARGIN;
		mn20_c = {1'b0, mn_q} + wrcm_pkg::SPAN_MIN;
		hit_c = (p12_c < mn20_c) ? mn20_c : p12_c;

		old_c = esel_q ? hi_q : {1'b0, lo_q};
		tgt_c = esel_q ? hi_t_q : lo_t_q;
		ema_in_c = 30'(old_c) * 30'd9 + 30'({tgt_c, 16'h0000}) + wrcm_pkg::EMA_ROUND;
		eprod_c = 61'(ediv_q) * 61'(wrcm_pkg::EMA_RECIP);
		eres_c = eprod_c[58:34];

		lo_one_c = {2'b00, lo_q} + {1'b0, wrcm_pkg::FX_ONE};
		span_c = ({1'b0, hi_q} > lo_one_c) ? hi_q - {1'b0, lo_q} : wrcm_pkg::FX_ONE;
		vfx_c = {row_rd_q, 16'h0000};
		diff_c = vfx_c - lo_q;
		num_c = {diff_c, 8'h00} - {8'h00, diff_c};
		mge_c = {1'b0, num_q} >= dsh_q;
		colj_c = col_q + CW'(j_q);
		in_range_c = colj_c < CW'(ROW_WIDTH);
		row_rd_en_c = (state_q == S_MRD) && in_range_c;
		last_res_c = (col_q + CW'(PPR)) >= CW'(ROW_WIDTH);
		out_load_c = (state_q == S_EMIT) && (!out_valid_q || out_ready);
	end

	assign pop = (state_q == S_IDLE) && q_valid;
	assign busy = busy_q;
	assign mem_raddr = {bank_q, i_q[AW-1:0]};

	always_ff @(posedge clk) begin
		if (hist_we_c) begin
			hist_mem[m_q] <= hist_wdata_c;
		end
		hist_rd_q <= hist_mem[hist_addr_c];
		if (row_we_c) begin
			row_mem[x_q] <= mnew_c;
		end
		if (row_rd_en_c) begin
			row_rd_q <= row_mem[XW'(colj_c)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			autoscale_q <= 1'b1;
			header_q <= wrcm_pkg::HEADER_ROWS_RST;
			scroll_q <= wrcm_pkg::SCROLL_ROWS_RST;
			lo_q <= wrcm_pkg::SCALE_LOW_RST;
			hi_q <= wrcm_pkg::SCALE_HIGH_RST;
			pos_q <= wrcm_pkg::SCROLL_POS_RST;
			busy_q <= 1'b0;
			bank_q <= 1'b0;
			dv_q <= '0;
			qs_q <= '0;
			rs_q <= '0;
			a_q <= '0;
			ar_q <= '0;
			nb_q <= '0;
			nbr_q <= '0;
			end_q <= '0;
			i_q <= '0;
			m_q <= '0;
			x_q <= '0;
			hvalid_q <= '0;
			nvalid_q <= '0;
			mn_q <= 8'hFF;
			cel_q <= '0;
			acc_q <= '0;
			hidx_q <= '0;
			lo_t_q <= '0;
			hi_t_q <= '0;
			esel_q <= 1'b0;
			ediv_q <= '0;
			span_q <= wrcm_pkg::FX_ONE;
			num_q <= '0;
			dsh_q <= '0;
			q8_q <= '0;
			scnt_q <= '0;
			col_q <= '0;
			j_q <= '0;
			for (int k = 0; k < PPR; k++) begin
				grp_q[k] <= '0;
				pix_out_q[k] <= '0;
			end
			out_valid_q <= 1'b0;
			col_out_q <= '0;
			row_out_q <= '0;
			last_out_q <= 1'b0;
		end else begin
			if (cfg.we) begin
				unique case (cfg.idx)
					wrcm_pkg::CFG_AUTOSCALE: begin
						if (cfg.data[0] != autoscale_q) begin
							autoscale_q <= cfg.data[0];
							if (!cfg.data[0]) begin
								lo_q <= '0;
								hi_q <= wrcm_pkg::SCALE_HIGH_FULL;
							end
						end
					end
					wrcm_pkg::CFG_HEADER_ROWS: header_q <= cfg.data;
					wrcm_pkg::CFG_SCROLL_ROWS: scroll_q <= cfg.data;
					default: ;
				endcase
			end

			if (out_valid_q && out_ready && !out_load_c) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						busy_q <= 1'b1;
						bank_q <= q_bank;
						dv_q <= q_n;
						pos_q <= new_pos_c;
						hvalid_q <= '0;
						nvalid_q <= '0;
						mn_q <= 8'hFF;
						x_q <= '0;
						state_q <= S_DIVN;
					end
				end
				S_DIVN: begin
					qs_q <= dprod_c[DSH +: NW];
					state_q <= S_DREM;
				end
				S_DREM: begin
					rs_q <= RW'(drem_c);
					a_q <= '0;
					ar_q <= '0;
					state_q <= S_PSET;
				end
				S_PSET: begin
					nb_q <= nb_c;
					nbr_q <= nbr_c;
					end_q <= end_c;
					i_q <= a_q;
					m_q <= '0;
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					m_q <= mnew_c;
					if (span_done_c) begin
						state_q <= (mnew_c != 8'd0) ? S_HRD : S_PNEXT;
					end else begin
						i_q <= i_q + NW'(1);
						state_q <= S_RD;
					end
				end
				S_HRD: begin
					state_q <= S_HWR;
				end
				S_HWR: begin
					hvalid_q[m_q] <= 1'b1;
					nvalid_q <= nvalid_q + HW'(1);
					if (m_q < mn_q) begin
						mn_q <= m_q;
					end
					state_q <= S_PNEXT;
				end
				S_PNEXT: begin
					a_q <= nb_q;
					ar_q <= nbr_q;
					if (x_q == XW'(ROW_WIDTH - 1)) begin
						state_q <= S_SCHK;
					end else begin
						x_q <= x_q + XW'(1);
						state_q <= S_PSET;
					end
				end
				S_SCHK: begin
					if (autoscale_q && (nvalid_q >= HW'(wrcm_pkg::MIN_VALID))) begin
						cel_q <= cel_prod_c[16 +: HW];
						hidx_q <= 8'd1;
						acc_q <= '0;
						state_q <= S_PRD;
					end else begin
						state_q <= S_MSTART;
					end
				end
				S_PRD: begin
					state_q <= S_PACC;
				end
				S_PACC: begin
					acc_q <= accn_c;
					// when the count never reaches the ceiling, index 255 is the answer
					if (accn_c >= cel_q || hidx_q == 8'hFF) begin
						lo_t_q <= {1'b0, mn_q};
						hi_t_q <= hit_c;
						esel_q <= 1'b0;
						state_q <= S_EINIT;
					end else begin
						hidx_q <= hidx_q + 8'd1;
						state_q <= S_PRD;
					end
				end
				S_EINIT: begin
					ediv_q <= ema_in_c;
					state_q <= S_EDIV;
				end
				S_EDIV: begin
					if (!esel_q) begin
						lo_q <= eres_c[23:0];
						esel_q <= 1'b1;
						state_q <= S_EINIT;
					end else begin
						hi_q <= eres_c;
						state_q <= S_MSTART;
					end
				end
				S_MSTART: begin
					span_q <= span_c;
					col_q <= '0;
					j_q <= '0;
					state_q <= S_MRD;
				end
				S_MRD: begin
					if (in_range_c) begin
						state_q <= S_MCALC;
					end else begin
						grp_q[j_q] <= '0;
						if (j_q == J_LAST) begin
							state_q <= S_EMIT;
						end else begin
							j_q <= j_q + JW'(1);
							state_q <= S_MRD;
						end
					end
				end
				S_MCALC: begin
					if (row_rd_q == 8'd0 || vfx_c <= lo_q) begin
						grp_q[j_q] <= (row_rd_q == 8'd0) ? wrcm_pkg::GREY565
							: wrcm_pkg::COLOUR_TABLE[0];
						if (j_q == J_LAST) begin
							state_q <= S_EMIT;
						end else begin
							j_q <= j_q + JW'(1);
							state_q <= S_MRD;
						end
					end else begin
						num_q <= num_c;
						dsh_q <= {span_q, 8'h00};
						scnt_q <= 4'd8;
						q8_q <= '0;
						state_q <= S_MDIV;
					end
				end
				S_MDIV: begin
					dsh_q <= {1'b0, dsh_q[32:1]};
					if (scnt_q == 4'd8) begin
						// quotient of 256 or more saturates
						if (mge_c) begin
							grp_q[j_q] <= wrcm_pkg::COLOUR_TABLE[255];
							if (j_q == J_LAST) begin
								state_q <= S_EMIT;
							end else begin
								j_q <= j_q + JW'(1);
								state_q <= S_MRD;
							end
						end else begin
							scnt_q <= 4'd7;
						end
					end else begin
						if (mge_c) begin
							num_q <= num_q - dsh_q[31:0];
						end
						q8_q <= {q8_q[6:0], mge_c};
						if (scnt_q == 4'd0) begin
							state_q <= S_MLUT;
						end else begin
							scnt_q <= scnt_q - 4'd1;
						end
					end
				end
				S_MLUT: begin
					grp_q[j_q] <= wrcm_pkg::COLOUR_TABLE[q8_q];
					if (j_q == J_LAST) begin
						state_q <= S_EMIT;
					end else begin
						j_q <= j_q + JW'(1);
						state_q <= S_MRD;
					end
				end
				S_EMIT: begin
					if (out_load_c) begin
						out_valid_q <= 1'b1;
						for (int k = 0; k < PPR; k++) begin
							pix_out_q[k] <= grp_q[k];
						end
						col_out_q <= 8'(col_q);
						row_out_q <= pos_q;
						last_out_q <= last_res_c;
						if (last_res_c) begin
							busy_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							col_q <= col_q + CW'(PPR);
							j_q <= '0;
							state_q <= S_MRD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_a = pix_out_q[0];
	assign pixel_b = pix_out_q[1];
	assign pixel_c = pix_out_q[2];
	assign pixel_d = pix_out_q[3];
	assign pixel_column = col_out_q;
	assign row_address = row_out_q;
	assign last_of_row = last_out_q;

	a_col_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (col_out_q[1:0] == 2'b00))
		else $error("result column not aligned to a group of four");

	a_span_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC) |-> (i_q < end_q))
		else $error("bin read past the end of the pixel span");

	a_row_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load_c && last_res_c) |=> (state_q == S_IDLE && !busy_q))
		else $error("engine did not release after the last transaction of a row");

	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> busy_q)
		else $error("engine working on a row without holding its bank");

endmodule
